/* hdl/dmdd_pkg.sv */
// shared types and constants of the depth map delta decoder
package dmdd_pkg;

	localparam int CfgDataW = 32;
	localparam int CfgIdxW  = 2;
	localparam int SumW     = 16;
	localparam int FifoDepth = 4;
	localparam int FifoAw   = $clog2(FifoDepth);
	localparam int DivSteps = 16;
	localparam int StepW    = $clog2(DivSteps);

	// register indexes of the configuration port
	typedef enum logic [CfgIdxW-1:0] {
		CFG_FRAME_LO = 2'd0,
		CFG_FRAME_HI = 2'd1,
		CFG_CLIP_LO  = 2'd2,
		CFG_CLIP_HI  = 2'd3
	} cfg_idx_t;

	typedef struct packed {
		logic [CfgDataW-1:0] frame_lo;
		logic [CfgDataW-1:0] frame_hi;
		logic [CfgDataW-1:0] clip_lo;
		logic [CfgDataW-1:0] clip_hi;
	} cfg_t;

	// one queue entry: updated row sum and its row end flag
	typedef struct packed {
		logic [SumW-1:0] sum;
		logic            last;
	} fifo_word_t;

	typedef struct packed {
		logic full;
		logic empty;
	} fifo_stat_t;

endpackage

/* hdl/dmdd_if.sv */
// stream interfaces for the pixel input and the depth output
interface dmdd_pixel_if;
	logic       valid;
	logic       ready;
	logic [7:0] delta_high;
	logic [7:0] delta_low;
	logic       row_last;

	modport source (output valid, output delta_high, output delta_low, output row_last,
		input ready);
	modport sink (input valid, input delta_high, input delta_low, input row_last,
		output ready);
endinterface

interface dmdd_depth_if;
	logic        valid;
	logic        ready;
	logic [15:0] norm_depth;
	logic        row_end;

	modport source (output valid, output norm_depth, output row_end, input ready);
	modport sink (input valid, input norm_depth, input row_end, output ready);
endinterface

/* hdl/dmdd_fifo.sv */
// short queue between the row sum front and the rescale back
module dmdd_fifo (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  dmdd_pkg::fifo_word_t wdata,
	input  logic                pop,
	output dmdd_pkg::fifo_word_t rdata,
	output dmdd_pkg::fifo_stat_t stat
);
	import dmdd_pkg::*;

	fifo_word_t        mem_q [FifoDepth];
	logic [FifoAw-1:0] wr_ptr_q;
	logic [FifoAw-1:0] rd_ptr_q;
	logic [FifoAw:0]   cnt_q;

	assign stat.full  = (cnt_q == (FifoAw+1)'(FifoDepth));
	assign stat.empty = (cnt_q == '0);
	assign rdata      = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end
endmodule

/* hdl/dmdd_front.sv */
// front: takes pixel words and keeps the wrapping row sum
module dmdd_front (
	input  logic                 clk,
	input  logic                 arst_n,
	dmdd_pixel_if.sink           pixel,
	input  dmdd_pkg::fifo_stat_t stat,
	output logic                 push,
	output dmdd_pkg::fifo_word_t wdata
);
	import dmdd_pkg::*;

	logic [SumW-1:0] sum_q;
	logic [SumW-1:0] sum_next;

	assign pixel.ready = !stat.full;
	assign push        = pixel.valid && pixel.ready;
	assign sum_next    = sum_q + {pixel.delta_high, pixel.delta_low};
	assign wdata.sum   = sum_next;
	assign wdata.last  = pixel.row_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
		end else if (push) begin
			sum_q <= pixel.row_last ? '0 : sum_next;
		end
	end
endmodule

/* hdl/dmdd_back.sv */
// back: exact rescale with rounding, clamping and a bit-serial divider
module dmdd_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  dmdd_pkg::cfg_t       cfg,
	input  dmdd_pkg::fifo_stat_t stat,
	input  dmdd_pkg::fifo_word_t rdata,
	output logic                 pop,
	dmdd_depth_if.source         depth
);
	import dmdd_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_PREP,
		ST_DIV,
		ST_DONE
	} state_t;

	state_t              state_q;
	logic [SumW-1:0]     v_q;
	logic                last_q;
	logic signed [49:0]  prod_q;
	logic signed [49:0]  offk_q;
	logic signed [32:0]  span_q;
	logic [31:0]         den_q;
	logic                den_ok_q;
	logic [50:0]         rem_q;
	logic [50:0]         dsh_q;
	logic [StepW-1:0]    step_q;
	logic [15:0]         quo_q;
	logic                out_valid_q;
	logic [15:0]         out_depth_q;
	logic                out_end_q;

	logic signed [32:0]  offs;
	logic signed [49:0]  offs_ext;
	logic signed [16:0]  v_ext;
	logic signed [49:0]  num;
	logic [50:0]         xval;
	logic [50:0]         dlim;
	logic                ge;

	// derived constants follow the registers, settled long before use
	assign offs     = $signed({1'b0, cfg.frame_lo}) - $signed({1'b0, cfg.clip_lo});
	assign offs_ext = 50'(offs);
	assign v_ext    = $signed({1'b0, v_q});

	always_ff @(posedge clk) begin
		offk_q   <= (offs_ext <<< 16) - offs_ext;
		span_q   <= $signed({1'b0, cfg.frame_hi}) - $signed({1'b0, cfg.frame_lo});
		den_q    <= cfg.clip_hi - cfg.clip_lo;
		den_ok_q <= (cfg.clip_hi > cfg.clip_lo);
	end

	assign num  = offk_q + prod_q;
	assign xval = {num, 1'b0} + 51'(den_q);
	assign dlim = 51'({den_q, 17'b0});
	assign ge   = (rem_q >= dsh_q);

	assign pop          = (state_q == ST_IDLE) && !stat.empty;
	assign depth.valid      = out_valid_q;
	assign depth.norm_depth = out_depth_q;
	assign depth.row_end    = out_end_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
			v_q         <= '0;
			last_q      <= 1'b0;
			prod_q      <= '0;
			rem_q       <= '0;
			dsh_q       <= '0;
			step_q      <= '0;
			quo_q       <= '0;
			out_depth_q <= '0;
			out_end_q   <= 1'b0;
		end else begin
			// output register: load a finished word, else drop the one just taken
			if ((state_q == ST_DONE) && (!out_valid_q || depth.ready)) begin
				out_valid_q <= 1'b1;
				out_depth_q <= quo_q;
				out_end_q   <= last_q;
			end else if (depth.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (!stat.empty) begin
						v_q     <= rdata.sum;
						last_q  <= rdata.last;
						state_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					// 17 by 33 bit signed product
					prod_q  <= 50'(v_ext) * 50'(span_q);
					state_q <= ST_PREP;
				end
				ST_PREP: begin
					if (!den_ok_q || num[49] || (num == '0)) begin
						quo_q   <= '0;
						state_q <= ST_DONE;
					end else if (xval >= dlim) begin
						// quotient would pass the top code: saturate
						quo_q   <= '1;
						state_q <= ST_DONE;
					end else begin
						rem_q   <= xval;
						dsh_q   <= 51'({den_q, 16'b0});
						step_q  <= StepW'(DivSteps - 1);
						quo_q   <= '0;
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					if (ge) begin
						rem_q <= rem_q - dsh_q;
					end
					quo_q  <= {quo_q[14:0], ge};
					dsh_q  <= dsh_q >> 1;
					step_q <= step_q - 1'b1;
					if (step_q == '0) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (!out_valid_q || depth.ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule

/* hdl/depth_map_delta_decoder_top.sv */
// depth map delta decoder top: config registers, front, queue and rescale back
// words pass the queue, then the back's idle, mul, prep, div and done states; zero and
//   saturated results skip the 16-step divider; the back takes no new word until done and
//   any depth stall are over; the front takes one word a cycle while the queue has room
// reset: arst_n clears the row sum, the queue, the back state and all four range registers
module depth_map_delta_decoder_top (
	input  logic                          clk,
	input  logic                          arst_n,
	dmdd_pixel_if.sink                    pixel,
	dmdd_depth_if.source                  depth,
	input  logic                          cfg_we,
	input  logic [dmdd_pkg::CfgIdxW-1:0]  cfg_index,
	input  logic [dmdd_pkg::CfgDataW-1:0] cfg_wdata
);
	import dmdd_pkg::*;

	// range registers, all unsigned fixed point in one shared format
	cfg_t       cfg_q;
	// queue handshake between front and back
	logic       push;
	logic       pop;
	fifo_word_t wdata;
	fifo_word_t rdata;
	fifo_stat_t stat;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_we) begin
			case (cfg_idx_t'(cfg_index))
				CFG_FRAME_LO: cfg_q.frame_lo <= cfg_wdata;
				CFG_FRAME_HI: cfg_q.frame_hi <= cfg_wdata;
				CFG_CLIP_LO:  cfg_q.clip_lo  <= cfg_wdata;
				CFG_CLIP_HI:  cfg_q.clip_hi  <= cfg_wdata;
				default:      cfg_q <= cfg_q;
			endcase
		end
	end

	// front: row sum accumulate, one pixel word per cycle while the queue has room
	dmdd_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.pixel  (pixel),
		.stat   (stat),
		.push   (push),
		.wdata  (wdata)
	);

	// decouples the pixel stream from the slower rescale
	dmdd_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (wdata),
		.pop    (pop),
		.rdata  (rdata),
		.stat   (stat)
	);

	// back: multiply, round, clamp and divide, with its own output register
	dmdd_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_q),
		.stat   (stat),
		.rdata  (rdata),
		.pop    (pop),
		.depth  (depth)
	);

	// an empty clip range can only ever give zero depth
	a_empty_range_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(depth.valid && (cfg_q.clip_hi <= cfg_q.clip_lo)) |-> (depth.norm_depth == '0))
		else $error("nonzero depth with empty clip range");

	// the front never writes a full queue
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !stat.full)
		else $error("queue overflow");

	// the back never reads an empty queue
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !stat.empty)
		else $error("queue underflow");

	// the queue cannot report full and empty at once
	a_stat_sane: assert property (@(posedge clk) disable iff (!arst_n)
		!(stat.full && stat.empty))
		else $error("queue status inconsistent");
endmodule

/* bench/tb.sv */
// self-checking bench for the depth map delta decoder: directed and random pixels
`timescale 1ns / 100ps

module tb;
	import dmdd_pkg::*;

	// one expected depth word
	typedef struct {
		logic [15:0] norm_depth;
		logic        row_end;
	} depth_word_t;

	// keeps its own copy of the range registers and the row sum, and the
	// depth words still owed by the block, oldest first
	class depth_tracker;
		bit [31:0]   frame_lo, frame_hi, clip_lo, clip_hi;
		bit [15:0]   row_sum;
		depth_word_t depth_due[$];
		int          errors;

		function new();
			frame_lo = 0;
			frame_hi = 0;
			clip_lo  = 0;
			clip_hi  = 0;
			row_sum  = 0;
			errors   = 0;
		endfunction

		function void set_range(cfg_idx_t idx, bit [31:0] value);
			case (idx)
				CFG_FRAME_LO: frame_lo = value;
				CFG_FRAME_HI: frame_hi = value;
				CFG_CLIP_LO:  clip_lo  = value;
				CFG_CLIP_HI:  clip_hi  = value;
				default: ;
			endcase
		endfunction

		// exact linear map of the row sum from frame range onto clip range,
		// rounded half away from zero and clamped to 16 bits
		function bit [15:0] rescale_sum(bit [15:0] s);
			longint    offs, span, num;
			bit [63:0] den, num_u, q;
			if (clip_hi <= clip_lo)
				return 16'd0;
			den  = {32'd0, clip_hi} - {32'd0, clip_lo};
			offs = longint'({32'd0, frame_lo}) - longint'({32'd0, clip_lo});
			span = longint'({32'd0, frame_hi}) - longint'({32'd0, frame_lo});
			num  = offs * 65535 + longint'({48'd0, s}) * span;
			if (num <= 0)
				return 16'd0;
			num_u = num;
			q = (2 * num_u + den) / (2 * den);
			if (q > 64'd65535)
				q = 64'd65535;
			return q[15:0];
		endfunction

		function void note_pixel(bit [7:0] dh, bit [7:0] dl, bit last);
			depth_word_t w;
			row_sum      = row_sum + {dh, dl};
			w.norm_depth = rescale_sum(row_sum);
			w.row_end    = last;
			depth_due    = {depth_due, w};
			if (last)
				row_sum = 0;
		endfunction

		function void check_depth(logic [15:0] norm_depth, logic row_end);
			depth_word_t w;
			if (depth_due.size() == 0) begin
				$error("depth word with no pixel pending: norm_depth %0d row_end %0d",
					norm_depth, row_end);
				errors++;
				return;
			end
			w = depth_due.pop_front();
			if (norm_depth !== w.norm_depth) begin
				$error("norm_depth: expected %0d, got %0d", w.norm_depth, norm_depth);
				errors++;
			end
			if (row_end !== w.row_end) begin
				$error("row_end: expected %0d, got %0d", w.row_end, row_end);
				errors++;
			end
		endfunction

		function int pending();
			return depth_due.size();
		endfunction
	endclass

	logic                clk;
	logic                arst_n;
	logic                cfg_we;
	logic [CfgIdxW-1:0]  cfg_index;
	logic [CfgDataW-1:0] cfg_wdata;

	dmdd_pixel_if pixel ();
	dmdd_depth_if depth ();

	depth_map_delta_decoder_top uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.pixel     (pixel),
		.depth     (depth),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	depth_tracker trk;

	// idle switches, flipped per phase so that some stretches run gap-free
	bit send_idle;
	bit recv_idle;
	int pixels_sent;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// hard stop well past the slowest legal run of about 1000 words
	initial begin
		#2_000_000;
		$display("end of test: mismatches");
		$finish;
	end

	// offer one pixel word after a random gap, return once it is taken
	task automatic send_pixel(bit [7:0] dh, bit [7:0] dl, bit last);
		int gap;
		gap = send_idle ? $urandom_range(0, 5) : 0;
		if (gap > 0) begin
			pixel.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		pixel.valid      <= 1'b1;
		pixel.delta_high <= dh;
		pixel.delta_low  <= dl;
		pixel.row_last   <= last;
		@(posedge clk);
		while (!pixel.ready)
			@(posedge clk);
		trk.note_pixel(dh, dl, last);
		pixels_sent++;
	endtask

	// stop sending and wait for every owed depth word
	task automatic drain();
		pixel.valid <= 1'b0;
		@(posedge clk);
		while (trk.pending() != 0)
			@(posedge clk);
	endtask

	// all four range registers, written back to back while the block is idle
	task automatic write_ranges(bit [31:0] f_lo, bit [31:0] f_hi, bit [31:0] c_lo,
		bit [31:0] c_hi);
		cfg_idx_t idx;
		bit [31:0] vals [4];
		vals[0] = f_lo;
		vals[1] = f_hi;
		vals[2] = c_lo;
		vals[3] = c_hi;
		for (int i = 0; i < 4; i++) begin
			idx = cfg_idx_t'(i);
			cfg_we    <= 1'b1;
			cfg_index <= idx;
			cfg_wdata <= vals[i];
			@(posedge clk);
			trk.set_range(idx, vals[i]);
		end
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// random ranges: mostly a frame range close to the clip range so that
	// outputs spread over the whole scale, sometimes anything at all
	task automatic pick_ranges();
		bit [31:0] den, c_lo, f_lo, f_hi;
		int kind;
		kind = $urandom_range(0, 9);
		if (kind == 0) begin
			write_ranges($urandom, $urandom, $urandom, $urandom);
		end else if (kind == 1) begin
			// corners of the register range
			write_ranges($urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'd0,
				$urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'd0,
				$urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'd0,
				$urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'd0);
		end else begin
			den  = $urandom_range(1, 32'd1 << $urandom_range(1, 28));
			c_lo = den + $urandom_range(0, 32'd1 << 30);
			f_lo = c_lo - (den >> 4) + $urandom_range(0, den >> 3);
			f_hi = f_lo + den - (den >> 3) + $urandom_range(0, den >> 2);
			if (kind == 2)
				write_ranges(f_hi, f_lo, c_lo, c_lo + den);   // reversed frame range
			else
				write_ranges(f_lo, f_hi, c_lo, c_lo + den);
		end
	endtask

	// depth side: random stalls before each word, check it when taken
	initial begin
		int stall;
		depth.ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			stall = recv_idle ? $urandom_range(0, 5) : 0;
			if (stall > 0) begin
				depth.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			depth.ready <= 1'b1;
			@(posedge clk);
			while (!depth.valid)
				@(posedge clk);
			trk.check_depth(depth.norm_depth, depth.row_end);
		end
	end

	// stimulus
	initial begin
		int row_len, row_pos, burst, waited;
		bit [7:0] dh, dl;
		bit last;

		trk              = new();
		send_idle        = 1'b1;
		recv_idle        = 1'b1;
		pixels_sent      = 0;
		arst_n           = 1'b0;
		cfg_we           = 1'b0;
		cfg_index        = '0;
		cfg_wdata        = '0;
		pixel.valid      = 1'b0;
		pixel.delta_high = 8'd0;
		pixel.delta_low  = 8'd0;
		pixel.row_last   = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset ranges: empty clip range, every word is zero
		send_pixel(8'hFF, 8'hFF, 1'b0);
		send_pixel(8'h00, 8'h01, 1'b1);
		drain();

		// identity map: depth equals the row sum; full scale, wrap, row clear
		write_ranges(32'd0, 32'h0001_0000, 32'd0, 32'h0001_0000);
		send_pixel(8'h00, 8'h00, 1'b0);
		send_pixel(8'hFF, 8'hFF, 1'b0);
		send_pixel(8'h00, 8'h01, 1'b0);   // sum wraps to zero
		send_pixel(8'h80, 8'h00, 1'b0);
		send_pixel(8'h7F, 8'hFF, 1'b1);
		send_pixel(8'h00, 8'h05, 1'b0);   // fresh row starts from zero
		send_pixel(8'h01, 8'h00, 1'b1);
		drain();

		// halving map: odd sums land on exact halves and round up
		write_ranges(32'd0, 32'd1, 32'd0, 32'd2);
		send_pixel(8'h00, 8'h01, 1'b0);
		send_pixel(8'h00, 8'h02, 1'b0);
		send_pixel(8'hFF, 8'hFC, 1'b1);
		drain();

		// reversed frame range: depth falls as the sum grows, down to zero
		write_ranges(32'hFFFF_FFFF, 32'd0, 32'd0, 32'hFFFF_FFFF);
		send_pixel(8'h00, 8'h00, 1'b0);
		send_pixel(8'h00, 8'h10, 1'b0);
		send_pixel(8'hFF, 8'hEF, 1'b1);
		drain();

		// narrow clip range: saturates at full scale
		write_ranges(32'd0, 32'hFFFF_FFFF, 32'd0, 32'd1);
		send_pixel(8'h00, 8'h00, 1'b0);
		send_pixel(8'h00, 8'h01, 1'b1);
		drain();

		// frame far below clip: negative numerator gives zero
		write_ranges(32'd0, 32'd1, 32'hFFFF_FF00, 32'hFFFF_FFFF);
		send_pixel(8'hFF, 8'hFF, 1'b1);
		drain();

		// equal clip bounds, nonzero: empty range again
		write_ranges(32'd5, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_pixel(8'h12, 8'h34, 1'b1);
		drain();

		// random phases: new ranges, new idle mix, rows of random length
		while (pixels_sent < 860) begin
			pick_ranges();
			send_idle = $urandom_range(0, 3) != 0;
			recv_idle = $urandom_range(0, 3) != 0;
			burst     = $urandom_range(40, 100);
			row_len   = $urandom_range(1, 48);
			row_pos   = 0;
			repeat (burst) begin
				if ($urandom_range(0, 1)) begin
					// typical depth step: small signed difference
					dl = 8'($urandom);
					dh = dl[7] ? 8'hFF : 8'h00;
				end else begin
					dh = 8'($urandom);
					dl = 8'($urandom);
				end
				if ($urandom_range(0, 9) == 0) begin
					last = 1'($urandom_range(0, 1));   // stray row marks
				end else begin
					last = (row_pos == row_len - 1);
				end
				if (last) begin
					row_pos = 0;
					row_len = $urandom_range(1, 48);
				end else begin
					row_pos++;
				end
				send_pixel(dh, dl, last);
				// now and then hold off until the block has emptied
				if ($urandom_range(0, 99) == 0)
					drain();
			end
			drain();
		end

		// bounded wait for stragglers, then a quiet tail to catch extra words
		pixel.valid <= 1'b0;
		waited = 0;
		while (trk.pending() != 0 && waited < 2000) begin
			@(posedge clk);
			waited++;
		end
		repeat (40) @(posedge clk);
		if (trk.errors == 0 && trk.pending() == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule
